// ===== rtl/core/programmable_dfa_matcher_assert.svh =====
// ----------------------------------------------------------------------------
// programmable_dfa_matcher assertion macros
// Concurrent assertion wrappers, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PROGRAMMABLE_DFA_MATCHER_ASSERT_SVH
`define PROGRAMMABLE_DFA_MATCHER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define DFAM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfa matcher assertion failed");
// Next-cycle implication.
`define DFAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfa matcher assertion failed");
`else
`define DFAM_ASSERT_IMP(lbl, ante, cons)
`define DFAM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/dfam_pkg.sv =====
// ----------------------------------------------------------------------------
// dfam_pkg
// Command codes, field widths and result constants of the DFA matcher.
// ----------------------------------------------------------------------------
package dfam_pkg;

  localparam int FIELD_W = 6;
  localparam int SYM_W   = 8;
  localparam int END_W   = 7;

  // Output buffer depth; covers the two pipeline stages plus slack.
  localparam int OFIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_WRITE_TRANS = 2'd0,
    CMD_MARK_ACCEPT = 2'd1,
    CMD_SYMBOL      = 2'd2,
    CMD_TEST_EMPTY  = 2'd3
  } dfam_cmd_t;

  // End state reported for a dead string.
  localparam logic signed [END_W-1:0] END_DEAD = 7'sh7F;

  typedef struct packed {
    logic                     accepted;
    logic signed [END_W-1:0]  end_state;
  } dfam_res_t;

endpackage

// ===== rtl/core/dfam_in_if.sv =====
// ----------------------------------------------------------------------------
// dfam_in_if
// Command word channel of the DFA matcher, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dfam_in_if import dfam_pkg::*; ();
  logic                valid;
  logic                ready;
  dfam_cmd_t           command;
  logic [FIELD_W-1:0]  state_index;
  logic [FIELD_W-1:0]  next_state;
  logic [SYM_W-1:0]    symbol;
  logic                start_of_string;
  logic                end_of_string;

  modport source (
    output valid, command, state_index, next_state, symbol,
           start_of_string, end_of_string,
    input  ready
  );
  modport sink (
    input  valid, command, state_index, next_state, symbol,
           start_of_string, end_of_string,
    output ready
  );
endinterface

// ===== rtl/core/dfam_out_if.sv =====
// ----------------------------------------------------------------------------
// dfam_out_if
// Result word channel of the DFA matcher, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dfam_out_if import dfam_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic signed [END_W-1:0]  end_state;

  modport source (output valid, accepted, end_state, input ready);
  modport sink   (input valid, accepted, end_state, output ready);
endinterface

// ===== rtl/core/programmable_dfa_matcher.sv =====
// ----------------------------------------------------------------------------
// programmable_dfa_matcher
// Table-driven DFA: transition table and accepting flags in synchronous RAMs.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while in_word.ready is high; the table
//   read data of one symbol is the read address of the next symbol.
// Result path: stage 1 and stage 2 registers, then the output buffer.
// Reset: synchronous, active low. A clearing pass then writes every table
//   entry dead and every flag zero, across all NUM_STATES*256 entries, with
//   in_word.ready low. Configuration writes are taken during the pass.
// ----------------------------------------------------------------------------
`include "programmable_dfa_matcher_assert.svh"

module programmable_dfa_matcher import dfam_pkg::*; #(
  parameter int NUM_STATES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  dfam_in_if.sink        in_word,
  dfam_out_if.source     out_word,
  input  logic           cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata
);

  // State number width and table geometry.
  localparam int SW        = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int AW        = SW + SYM_W;
  localparam int TBL_DEPTH = NUM_STATES * (1 << SYM_W);
  localparam int PTR_W     = $clog2(OFIFO_DEPTH);
  localparam int CNT_W     = $clog2(OFIFO_DEPTH + 1);

  // A state as held in the table and the pipeline: live bit plus number.
  typedef struct packed {
    logic          live;
    logic [SW-1:0] st;
  } st_t;

  localparam st_t ST_DEAD = '{live: 1'b0, st: '0};

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [FIELD_W-1:0] cfg_initial_state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_initial_state_r <= '0;
    end else if (cfg_we) begin
      cfg_initial_state_r <= cfg_wdata;
    end
  end

  // Start state; an initial state beyond the table starts dead.
  st_t init_st;
  assign init_st = '{live: (32'(cfg_initial_state_r) < NUM_STATES),
                     st:   SW'(cfg_initial_state_r)};

  // --------------------------------------------------------------------------
  // Clearing pass after reset
  // --------------------------------------------------------------------------
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      // advance one table entry a cycle; drop busy after the last one
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(TBL_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic in_acc;
  logic idx_ok;
  logic nxt_ok;
  logic is_write;
  logic is_mark;
  logic is_symbol;
  logic is_test;

  assign in_acc    = in_word.valid && in_word.ready;
  assign idx_ok    = 32'(in_word.state_index) < NUM_STATES;
  assign nxt_ok    = 32'(in_word.next_state) < NUM_STATES;
  assign is_write  = (in_word.command == CMD_WRITE_TRANS);
  assign is_mark   = (in_word.command == CMD_MARK_ACCEPT);
  assign is_symbol = (in_word.command == CMD_SYMBOL);
  assign is_test   = (in_word.command == CMD_TEST_EMPTY);

  // --------------------------------------------------------------------------
  // Pipeline registers
  //   stage 0: accept word, read table at {source state, symbol}
  //   stage 1: table data forms the new state; read its accepting flag
  //   stage 2: build the result word and push it into the output buffer
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic s1_lookup_r;
  logic s1_eos_r;
  logic s1_emit_r;
  st_t  s1_src_r;
  logic s2_valid_r;
  st_t  s2_res_r;
  st_t  cur_r;

  st_t  tbl_rd_r;
  logic flag_rd_r;

  st_t  res;
  st_t  cur_fwd;
  st_t  src;

  always_comb begin
    // State after stage 1: table data for a symbol, start state for a test.
    if (s1_lookup_r) begin
      res = '{live: s1_src_r.live && tbl_rd_r.live, st: tbl_rd_r.st};
    end else begin
      res = s1_src_r;
    end
    // Forward the fresh state to the word now in stage 0; a string end kills it.
    if (s1_valid_r && s1_lookup_r) begin
      cur_fwd = s1_eos_r ? ST_DEAD : res;
    end else begin
      cur_fwd = cur_r;
    end
    src = in_word.start_of_string ? init_st : cur_fwd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      cur_r      <= ST_DEAD;
    end else begin
      s1_valid_r <= in_acc && (is_symbol || is_test);
      s2_valid_r <= s1_valid_r && s1_emit_r;
      cur_r      <= cur_fwd;
    end
  end

  always_ff @(posedge clk) begin
    s1_lookup_r <= is_symbol;
    s1_eos_r    <= in_word.end_of_string;
    s1_emit_r   <= is_test || in_word.end_of_string;
    s1_src_r    <= is_symbol ? src : init_st;
    s2_res_r    <= res;
  end

  // --------------------------------------------------------------------------
  // Transition table RAM: one write port, one registered read port
  // --------------------------------------------------------------------------
  st_t           tbl_mem [TBL_DEPTH];
  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  st_t           tbl_wdata;
  logic [AW-1:0] tbl_raddr;

  assign tbl_we    = clr_busy_r || (in_acc && is_write && idx_ok && nxt_ok);
  assign tbl_waddr = clr_busy_r ? clr_addr_r : {SW'(in_word.state_index), in_word.symbol};
  assign tbl_wdata = clr_busy_r ? ST_DEAD : st_t'{live: 1'b1, st: SW'(in_word.next_state)};
  assign tbl_raddr = {src.st, in_word.symbol};

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  // --------------------------------------------------------------------------
  // Accepting flag RAM; a mark is written at accept, at the same edge as the
  // stage 1 read of the word ahead, so an earlier string sees the old flag.
  // --------------------------------------------------------------------------
  logic          flag_mem [NUM_STATES];
  logic          flag_we;
  logic [SW-1:0] flag_waddr;
  logic          flag_wdata;

  assign flag_we    = clr_busy_r || (in_acc && is_mark && idx_ok);
  assign flag_waddr = clr_busy_r ? clr_addr_r[AW-1:SYM_W] : SW'(in_word.state_index);
  assign flag_wdata = !clr_busy_r;

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rd_r <= flag_mem[res.st];
  end

  // --------------------------------------------------------------------------
  // Output buffer; input is held off unless every word in flight has room.
  // --------------------------------------------------------------------------
  dfam_res_t        ofifo_mem [OFIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] fifo_cnt_r;
  logic             push;
  logic             pop;
  dfam_res_t        push_word;
  logic [CNT_W:0]   pending;

  assign push = s2_valid_r;
  assign pop  = out_word.valid && out_word.ready;

  assign push_word.accepted  = s2_res_r.live && flag_rd_r;
  assign push_word.end_state = s2_res_r.live ? END_W'(s2_res_r.st) : END_DEAD;

  assign pending = (CNT_W+1)'(fifo_cnt_r)
                 + (CNT_W+1)'(s1_valid_r && s1_emit_r)
                 + (CNT_W+1)'(s2_valid_r);

  assign in_word.ready = !clr_busy_r && (pending < (CNT_W+1)'(OFIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      ofifo_mem[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign out_word.valid     = (fifo_cnt_r != '0);
  assign out_word.accepted  = ofifo_mem[rd_ptr_r].accepted;
  assign out_word.end_state = ofifo_mem[rd_ptr_r].end_state;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DFAM_ASSERT_IMP(a_clear_quiet, clr_busy_r, !in_word.ready && !s1_valid_r && !s2_valid_r && fifo_cnt_r == '0)
  `DFAM_ASSERT_IMP(a_no_overflow, push, fifo_cnt_r < CNT_W'(OFIFO_DEPTH))
  `DFAM_ASSERT_IMP(a_dead_rejects, out_word.valid && out_word.end_state == END_DEAD, !out_word.accepted)
  `DFAM_ASSERT_NEXT(a_end_kills, s1_valid_r && s1_lookup_r && s1_eos_r, !cur_r.live)

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb - DFA matcher testbench
// Drives command words into the matcher and keeps its own copy of the
// transition table, the accepting flags and the string state. Every result
// word is checked against the expected result in order. Three handshake mixes
// are run, each with its own initial state, ending with a long receiver stall.
// ----------------------------------------------------------------------------
module tb import dfam_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DFA_STATES     = 64;
  localparam int SEG_WORDS      = 430;     // random words per phase
  localparam int SETTLE_CYCLES  = 8;       // lets the pipeline settle
  localparam int HOLDOFF_CYCLES = 300;
  // Clearing pass plus ~1300 words that at worst wait out sender gaps and
  // receiver stalls, then taken many times over.
  localparam int RUN_LIMIT      = 400000;

  // One command word as it crosses the input channel.
  typedef struct {
    dfam_cmd_t          cmd;
    logic [FIELD_W-1:0] state_index;
    logic [FIELD_W-1:0] next_state;
    logic [SYM_W-1:0]   symbol;
    logic               start_mark;
    logic               end_mark;
  } dfa_word_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [FIELD_W-1:0] cfg_wdata;

  dfam_in_if  in_if ();
  dfam_out_if out_if ();

  programmable_dfa_matcher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_if),
    .out_word  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow automaton: -1 stands for the dead state.
  int trans_next [DFA_STATES][256];
  bit accept_flag [DFA_STATES];
  int cur_state;
  int init_state;

  dfa_word_t pending_words[$];
  dfam_res_t expected_results[$];
  dfa_word_t drive_word;
  dfam_res_t got_res, exp_res, new_res;

  // Current random machine, used to build well-formed strings.
  int               mach_states[$];
  logic [SYM_W-1:0] mach_syms[$];

  int  send_idle_pct, recv_idle_pct;
  bit  word_taken;
  bit  rcv_hold;
  bit  holdoff_armed;
  int  cycle_count;
  int  words_queued, words_accepted;
  int  results_checked, accept_hits, dead_hits;
  int  strings_ended, empty_tests;
  int  mismatches;

  function automatic dfa_word_t mk_word(input dfam_cmd_t c, input int sidx, input int nxt,
                                        input int sym, input bit sos, input bit eos);
    dfa_word_t w;
    w.cmd         = c;
    w.state_index = sidx[FIELD_W-1:0];
    w.next_state  = nxt[FIELD_W-1:0];
    w.symbol      = sym[SYM_W-1:0];
    w.start_mark  = sos;
    w.end_mark    = eos;
    return w;
  endfunction

  function automatic void queue_word(input dfa_word_t w);
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // Result word for a string that stopped in state st.
  function automatic dfam_res_t result_for(input int st);
    dfam_res_t r;
    if (st < 0) begin
      r.accepted  = 1'b0;
      r.end_state = END_DEAD;
    end else begin
      r.accepted  = accept_flag[st];
      r.end_state = st[END_W-1:0];
    end
    return r;
  endfunction

  // Advance the shadow automaton by one accepted word; return 1 when the
  // word ends a string or tests the empty string, with the result in r.
  function automatic bit advance_dfa(input dfa_word_t w, output dfam_res_t r);
    int st;
    r = '0;
    case (w.cmd)
      CMD_WRITE_TRANS: begin
        trans_next[w.state_index][w.symbol] = int'(w.next_state);
        return 1'b0;
      end
      CMD_MARK_ACCEPT: begin
        accept_flag[w.state_index] = 1'b1;
        return 1'b0;
      end
      CMD_SYMBOL: begin
        st = w.start_mark ? init_state : cur_state;
        if (st >= 0) st = trans_next[st][w.symbol];
        if (w.end_mark) begin
          r = result_for(st);
          cur_state = -1;
          strings_ended++;
          return 1'b1;
        end
        cur_state = st;
        return 1'b0;
      end
      default: begin
        // empty string test leaves the string in progress alone
        r = result_for(init_state);
        empty_tests++;
        return 1'b1;
      end
    endcase
  endfunction

  // Program a small random machine around the initial state; return the
  // number of words queued.
  function automatic int build_machine();
    int n_st, n_sym, cnt;
    cnt = 0;
    n_st  = $urandom_range(3, 8);
    n_sym = $urandom_range(2, 6);
    mach_states.delete();
    mach_syms.delete();
    mach_states.push_back(init_state);
    while (mach_states.size() < n_st) mach_states.push_back($urandom_range(DFA_STATES - 1));
    while (mach_syms.size() < n_sym) mach_syms.push_back(SYM_W'($urandom_range(255)));
    foreach (mach_states[s]) begin
      foreach (mach_syms[a]) begin
        // leave some holes so strings can still fall into the dead state
        if ($urandom_range(99) < 85) begin
          queue_word(mk_word(CMD_WRITE_TRANS, mach_states[s],
                             mach_states[$urandom_range(mach_states.size() - 1)],
                             mach_syms[a], $urandom_range(1), $urandom_range(1)));
          cnt++;
        end
      end
      if ($urandom_range(99) < 35) begin
        queue_word(mk_word(CMD_MARK_ACCEPT, mach_states[s], $urandom_range(63),
                           $urandom_range(255), $urandom_range(1), $urandom_range(1)));
        cnt++;
      end
    end
    return cnt;
  endfunction

  // Mostly strings over the machine's alphabet, some empty tests and noise.
  function automatic void run_random(input int budget);
    int               issued, len, pick;
    bit               rebuilt, sos, eos;
    logic [SYM_W-1:0] sym;
    issued  = build_machine();
    rebuilt = 1'b0;
    while (issued < budget) begin
      if (!rebuilt && issued >= budget / 2) begin
        issued += build_machine();
        rebuilt = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) != 0) sym = mach_syms[$urandom_range(mach_syms.size() - 1)];
          else sym = SYM_W'($urandom_range(255));
          // now and then drop a start or end mark to break the string
          sos = (i == 0) && ($urandom_range(19) != 0);
          eos = (i == len - 1) && ($urandom_range(19) != 0);
          queue_word(mk_word(CMD_SYMBOL, $urandom_range(63), $urandom_range(63), sym, sos, eos));
        end
        issued += len;
      end else if (pick < 88) begin
        queue_word(mk_word(CMD_TEST_EMPTY, $urandom_range(63), $urandom_range(63),
                           $urandom_range(255), $urandom_range(1), $urandom_range(1)));
        issued++;
      end else begin
        queue_word(mk_word(dfam_cmd_t'($urandom_range(3)), $urandom_range(63),
                           $urandom_range(63), $urandom_range(255),
                           $urandom_range(1), $urandom_range(1)));
        issued++;
      end
    end
  endfunction

  function automatic void queue_directed();
    // empty table: a one-symbol string dies at once
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'h00, 1, 1));
    // empty string before and after marking the initial state
    queue_word(mk_word(CMD_TEST_EMPTY,  0,  0, 8'h00, 0, 0));
    queue_word(mk_word(CMD_MARK_ACCEPT, 0,  0, 8'h00, 0, 0));
    queue_word(mk_word(CMD_TEST_EMPTY,  0,  0, 8'h00, 0, 0));
    // transitions at the extremes of state and symbol; marks on a write do nothing
    queue_word(mk_word(CMD_WRITE_TRANS, 0,  63, 8'h00, 0, 0));
    queue_word(mk_word(CMD_WRITE_TRANS, 63, 0,  8'hFF, 0, 0));
    queue_word(mk_word(CMD_WRITE_TRANS, 0,  42, 8'hA5, 1, 1));
    queue_word(mk_word(CMD_MARK_ACCEPT, 63, 0,  8'h00, 0, 0));
    // start and end on the same symbol
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'h00, 1, 1));
    // three symbols, 0 -> 63 -> 0 -> 63
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'h00, 1, 0));
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'hFF, 0, 0));
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'h00, 0, 1));
    // no start mark: continue from the dead state left by the last end
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'h00, 0, 1));
    // missing transition, then the dead state swallows the rest
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'hA5, 1, 0));
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'h5A, 0, 0));
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'h00, 0, 1));
    // a second start mark restarts the string
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'h00, 1, 0));
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'h00, 1, 1));
    // empty test in the middle of a string
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'h00, 1, 0));
    queue_word(mk_word(CMD_TEST_EMPTY,  0,  0, 8'h00, 0, 0));
    queue_word(mk_word(CMD_SYMBOL,      0,  0, 8'hFF, 0, 1));
    // overwrite a transition
    queue_word(mk_word(CMD_WRITE_TRANS, 0,  21, 8'h00, 0, 0));
    queue_word(mk_word(CMD_SYMBOL,      0,  0,  8'h00, 1, 1));
  endfunction

  // Hold until every queued word is taken and every result is back, then
  // let the pipeline settle so the block is idle for a register write.
  task automatic wait_quiet();
    do @(negedge clk); while (words_accepted != words_queued || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_initial_state(input int v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[FIELD_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    init_state = v & 6'h3F;
  endtask

  task automatic set_mode(input int snd_pct, input int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: hold a word until it is taken, then advance to the next one or
  // drop valid for an idle cycle.
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || word_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_word = pending_words.pop_front();
        in_if.valid           <= 1'b1;
        in_if.command         <= drive_word.cmd;
        in_if.state_index     <= drive_word.state_index;
        in_if.next_state      <= drive_word.next_state;
        in_if.symbol          <= drive_word.symbol;
        in_if.start_of_string <= drive_word.start_mark;
        in_if.end_of_string   <= drive_word.end_mark;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off below.
  always @(negedge clk) begin
    out_if.ready <= rst_n && !rcv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver stall while the sender keeps offering words, so the
  // output buffer fills and the block has to push back on its input.
  initial begin : receiver_holdoff
    rcv_hold = 1'b0;
    wait (holdoff_armed);
    repeat (40) @(negedge clk);
    rcv_hold <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(negedge clk);
    rcv_hold <= 1'b0;
  end

  // Monitor: check the result word first, then advance the shadow automaton
  // with the command word taken at the same edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    word_taken  <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      got_res.accepted  = out_if.accepted;
      got_res.end_state = out_if.end_state;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: accepted=%0b end_state=%0d",
                   got_res.accepted, got_res.end_state);
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        if (exp_res.accepted) accept_hits++;
        if (exp_res.end_state == END_DEAD) dead_hits++;
        if (got_res.accepted !== exp_res.accepted || got_res.end_state !== exp_res.end_state) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected accepted=%0b end_state=%0d, got accepted=%0b end_state=%0d",
                     results_checked, exp_res.accepted, exp_res.end_state,
                     got_res.accepted, got_res.end_state);
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      words_accepted++;
      if (advance_dfa(mk_word(in_if.command, in_if.state_index, in_if.next_state, in_if.symbol,
                              in_if.start_of_string, in_if.end_of_string), new_res))
        expected_results.push_back(new_res);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= RUN_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int mid_state;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_if.valid           = 1'b0;
    in_if.command         = CMD_WRITE_TRANS;
    in_if.state_index     = '0;
    in_if.next_state      = '0;
    in_if.symbol          = '0;
    in_if.start_of_string = 1'b0;
    in_if.end_of_string   = 1'b0;
    out_if.ready          = 1'b0;
    holdoff_armed         = 1'b0;
    set_mode(0, 0);
    foreach (trans_next[s, a]) trans_next[s][a] = -1;
    foreach (accept_flag[s]) accept_flag[s] = 1'b0;
    cur_state  = -1;
    init_state = 0;

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Phase 1: sender mostly busy, receiver mostly stalled. The register
    // write lands during the clearing pass, which the block allows.
    set_initial_state(0);
    set_mode(12, 83);
    queue_directed();
    run_random(SEG_WORDS);
    wait_quiet();

    // Phase 2: roles swapped, start from the top state.
    set_initial_state(DFA_STATES - 1);
    set_mode(83, 12);
    run_random(SEG_WORDS);
    wait_quiet();

    // Phase 3: no idling at all, with the long receiver stall.
    mid_state = $urandom_range(1, DFA_STATES - 2);
    set_initial_state(mid_state);
    set_mode(0, 0);
    holdoff_armed = 1'b1;
    run_random(SEG_WORDS);
    wait_quiet();

    $display("Covered %0d command words in three handshake mixes, initial states 0, %0d and %0d.",
             words_accepted, DFA_STATES - 1, mid_state);
    $display("Checked %0d results (%0d string ends, %0d empty tests; %0d accepting, %0d dead).",
             results_checked, strings_ended, empty_tests, accept_hits, dead_hits);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
